// ===== src/dbpc_pkg.sv =====
package dbpc_pkg;

  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned RES_W     = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TICKS_W-1:0] LONG_TICKS_RST = 16'd700;
  localparam logic [TICKS_W-1:0] ELAPSED_MAX    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_LONG_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_LONG_TICKS  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_POWER_EDGE = 2'd0,
    KIND_USER_EDGE  = 2'd1,
    KIND_TICK       = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pressed;
  } item_t;

  // packed MSB first, so power_short lands in bit 0
  typedef struct packed {
    logic user_long;
    logic user_short;
    logic power_long;
    logic power_short;
  } result_t;

endpackage

// ===== src/dual_button_press_classifier_unit.sv =====
// Classifies POWER and USER button activity into short and long presses. Each input
// transfer is a button edge (kind 0 POWER, 1 USER; pressed=1 on press) or a 1 ms tick
// (kind 2); kind 3 is ignored. Every input transfer yields exactly one output transfer
// with four flags. Throughput is one transfer per clock unless out_tready stalls the
// output; input and result registers surround the state update. The user must write
// thresholds through cfg_* only while no transfer is in flight; it is not enforced.
module dual_button_press_classifier_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dbpc_pkg::IN_DATA_W-1:0]       in_tdata,   // [0] pressed, rest zero
  input  logic [dbpc_pkg::KIND_W-1:0]          in_tuser,   // [1:0] req_type
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] power_short, [1] power_long, [2] user_short, [3] user_long, rest zero
  output logic [dbpc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 cfg_we,
  input  logic [dbpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dbpc_pkg::TICKS_W-1:0]         cfg_wdata
);

  dbpc_pkg::item_t   item;
  dbpc_pkg::result_t res;
  logic              take;
  logic              fire;

  dbpc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .item      (item),
    .fire      (fire)
  );

  dbpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .fire      (fire),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  dbpc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/dbpc_in_stage.sv =====
module dbpc_in_stage (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dbpc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [dbpc_pkg::KIND_W-1:0]          in_tuser,
  input  logic                                 take,
  output dbpc_pkg::item_t                      item,
  output logic                                 fire
);

  logic                        valid_r, valid_nxt;
  logic [dbpc_pkg::KIND_W-1:0] kind_r;
  logic                        pressed_r;
  logic                        in_xfer;

  assign fire      = valid_r && take;
  assign in_tready = !valid_r || take;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r    <= in_tuser;
      pressed_r <= in_tdata[0];
    end
  end

  assign item.kind    = kind_r;
  assign item.pressed = pressed_r;

endmodule

// ===== src/dbpc_core.sv =====
module dbpc_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dbpc_pkg::item_t                   item,
  input  logic                              fire,
  input  logic                              cfg_we,
  input  logic [dbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dbpc_pkg::TICKS_W-1:0]      cfg_wdata,
  output dbpc_pkg::result_t                 res
);

  logic [dbpc_pkg::TICKS_W-1:0] power_long_ticks_r;
  logic [dbpc_pkg::TICKS_W-1:0] user_long_ticks_r;

  logic user_down_r, user_down_nxt;
  logic power_cand_r, power_cand_nxt;
  logic power_supp_r, power_supp_nxt;
  logic power_long_done_r, power_long_done_nxt;
  logic user_log_down_r, user_log_down_nxt;
  logic user_long_done_r, user_long_done_nxt;
  logic [dbpc_pkg::TICKS_W-1:0] power_elapsed_r, power_elapsed_nxt;
  logic [dbpc_pkg::TICKS_W-1:0] user_elapsed_r, user_elapsed_nxt;

  logic p_short, p_long, u_short, u_long;
  logic u_end_short;
  logic [dbpc_pkg::TICKS_W-1:0] power_inc, user_inc;

  // short USER press if a logical press ends now without a long press
  assign u_end_short = user_log_down_r && !user_long_done_r;

  assign power_inc = (power_elapsed_r == dbpc_pkg::ELAPSED_MAX) ?
                     power_elapsed_r : power_elapsed_r + 16'd1;
  assign user_inc  = (user_elapsed_r == dbpc_pkg::ELAPSED_MAX) ?
                     user_elapsed_r : user_elapsed_r + 16'd1;

  always_comb begin
    user_down_nxt       = user_down_r;
    power_cand_nxt      = power_cand_r;
    power_supp_nxt      = power_supp_r;
    power_long_done_nxt = power_long_done_r;
    user_log_down_nxt   = user_log_down_r;
    user_long_done_nxt  = user_long_done_r;
    power_elapsed_nxt   = power_elapsed_r;
    user_elapsed_nxt    = user_elapsed_r;
    p_short = 1'b0;
    p_long  = 1'b0;
    u_short = 1'b0;
    u_long  = 1'b0;
    case (dbpc_pkg::kind_t'(item.kind))
      dbpc_pkg::KIND_POWER_EDGE: begin
        if (item.pressed) begin
          power_long_done_nxt = 1'b0;
          if (user_down_r) begin
            power_cand_nxt = 1'b0;
            power_supp_nxt = 1'b1;
          end else begin
            power_cand_nxt    = 1'b1;
            power_supp_nxt    = 1'b0;
            power_elapsed_nxt = '0;
          end
        end else if (!power_cand_r) begin
          if (power_supp_r && user_down_r) begin
            u_short             = u_end_short;
            user_log_down_nxt   = 1'b0;
            user_long_done_nxt  = user_log_down_r ? 1'b0 : user_long_done_r;
            user_down_nxt       = 1'b0;
          end
          power_supp_nxt = 1'b0;
        end else begin
          power_cand_nxt = 1'b0;
          if (power_supp_r || user_down_r) begin
            power_supp_nxt      = 1'b0;
            u_short             = u_end_short;
            user_log_down_nxt   = 1'b0;
            user_long_done_nxt  = user_log_down_r ? 1'b0 : user_long_done_r;
            user_down_nxt       = 1'b0;
          end else if (power_long_done_r) begin
            power_long_done_nxt = 1'b0;
          end else begin
            p_short = 1'b1;
          end
        end
      end
      dbpc_pkg::KIND_USER_EDGE: begin
        if (item.pressed) begin
          user_down_nxt = 1'b1;
          if (!user_log_down_r) begin
            user_log_down_nxt  = 1'b1;
            user_long_done_nxt = 1'b0;
            user_elapsed_nxt   = '0;
            if (power_cand_r) begin
              power_supp_nxt = 1'b1;
            end
          end
        end else begin
          user_down_nxt      = 1'b0;
          u_short            = u_end_short;
          user_log_down_nxt  = 1'b0;
          user_long_done_nxt = user_log_down_r ? 1'b0 : user_long_done_r;
        end
      end
      dbpc_pkg::KIND_TICK: begin
        if (power_cand_r) begin
          power_elapsed_nxt = power_inc;
          if (!power_supp_r && !power_long_done_r && power_inc >= power_long_ticks_r) begin
            power_long_done_nxt = 1'b1;
            p_long              = 1'b1;
          end
        end
        if (user_log_down_r) begin
          user_elapsed_nxt = user_inc;
          if (!user_long_done_r && user_inc >= user_long_ticks_r) begin
            user_long_done_nxt = 1'b1;
            u_long             = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_long_ticks_r <= dbpc_pkg::LONG_TICKS_RST;
      user_long_ticks_r  <= dbpc_pkg::LONG_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == dbpc_pkg::CFG_POWER_LONG_TICKS) begin
        power_long_ticks_r <= cfg_wdata;
      end
      if (cfg_index == dbpc_pkg::CFG_USER_LONG_TICKS) begin
        user_long_ticks_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_down_r       <= 1'b0;
      power_cand_r      <= 1'b0;
      power_supp_r      <= 1'b0;
      power_long_done_r <= 1'b0;
      user_log_down_r   <= 1'b0;
      user_long_done_r  <= 1'b0;
      power_elapsed_r   <= '0;
      user_elapsed_r    <= '0;
    end else if (fire) begin
      user_down_r       <= user_down_nxt;
      power_cand_r      <= power_cand_nxt;
      power_supp_r      <= power_supp_nxt;
      power_long_done_r <= power_long_done_nxt;
      user_log_down_r   <= user_log_down_nxt;
      user_long_done_r  <= user_long_done_nxt;
      power_elapsed_r   <= power_elapsed_nxt;
      user_elapsed_r    <= user_elapsed_nxt;
    end
  end

  assign res.power_short = p_short;
  assign res.power_long  = p_long;
  assign res.user_short  = u_short;
  assign res.user_long   = u_long;

  a_user_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    user_long_done_r |-> user_log_down_r)
    else $error("user long flag set without a logical USER press");

  a_edge_no_long: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.kind != dbpc_pkg::KIND_TICK) |-> (!p_long && !u_long))
    else $error("long press reported on a non-tick item");

  a_tick_no_short: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.kind == dbpc_pkg::KIND_TICK) |-> (!p_short && !u_short))
    else $error("short press reported on a tick");

  a_user_long_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && u_long) |=> user_long_done_r)
    else $error("user long press not latched");

endmodule

// ===== src/dbpc_out_stage.sv =====
module dbpc_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  dbpc_pkg::result_t                   res,
  output logic                                take,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dbpc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic              valid_r, valid_nxt;
  dbpc_pkg::result_t data_r;

  assign take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(dbpc_pkg::OUT_DATA_W - dbpc_pkg::RES_W){1'b0}}, data_r};

endmodule
